@@ rtl/core/xsde_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xsde_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;

  // Derived widths.
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int SW = $clog2(SCREEN_HEIGHT + 15);
  localparam int CW = $clog2(ROW_BYTES);
  localparam int AW = $clog2(STORE_BYTES);

  // Command queue between the front and back halves.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [3:0] row_offset;
    logic [7:0] row_bits;
    logic       first_row;
    logic       last_row;
    logic [7:0] read_addr;
  } item_t;

  typedef struct packed {
    logic       collision;
    logic       sprite_done;
    logic [7:0] read_data;
  } result_t;

  // Classified command as it sits in the queue.
  typedef struct packed {
    kind_e         op;
    logic          first_row;
    logic          last_row;
    logic          in_range;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [7:0]    pat_a;
    logic [7:0]    pat_b;
  } cmd_t;

  typedef logic [255:0][XW-1:0]     xmod_tab_t;
  typedef logic [255:0][YW-1:0]     ymod_tab_t;
  typedef logic [2**SW-1:0][YW-1:0] rmod_tab_t;

  function automatic xmod_tab_t build_xmod();
    xmod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = XW'(i % SCREEN_WIDTH);
    end
    return t;
  endfunction

  function automatic ymod_tab_t build_ymod();
    ymod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = YW'(i % SCREEN_HEIGHT);
    end
    return t;
  endfunction

  function automatic rmod_tab_t build_rmod();
    rmod_tab_t t;
    for (int i = 0; i < 2**SW; i++) begin
      t[i] = YW'(i % SCREEN_HEIGHT);
    end
    return t;
  endfunction

  localparam xmod_tab_t XMOD_TAB = build_xmod();
  localparam ymod_tab_t YMOD_TAB = build_ymod();
  localparam rmod_tab_t RMOD_TAB = build_rmod();

  // Reverses bit order so that bit k is pixel k counted from the left.
  function automatic logic [7:0] flip8(logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/xor_sprite_draw_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                       Payload
// command   in         start high while busy is low    item_i   (xsde_pkg::item_t)
// result    out        result_valid_o, one-cycle pulse result_o (xsde_pkg::result_t)
//
// In the back end a draw reads the first byte, then writes it and reads the second,
// then writes the second; a read reads its byte and then returns it; a clear is done
// when taken. The frame store's single read port and single write port set this order.
// Reset clears the valid bit of every frame byte at once, so no clearing pass is run.
// The result receiver cannot stall; the two-entry command queue lets the front end
// keep accepting while the back end works, and busy rises only when it is full.

module xor_sprite_draw_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire xsde_pkg::item_t item_i,
  output logic                 result_valid_o,
  output xsde_pkg::result_t    result_o
);

  // Front end: classifies each command transaction and folds the coordinates
  // into store addresses and two byte-aligned pixel masks.
  logic           push;
  logic           queue_full;
  xsde_pkg::cmd_t front_cmd;

  // Queue output toward the back end.
  logic           queue_valid;
  logic           pop;
  xsde_pkg::cmd_t back_cmd;

  assign busy = queue_full;

  xsde_front u_front (
    .start        (start),
    .item_i       (item_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  // The queue decouples acceptance from execution so that a clear or read can
  // be taken in while a sprite row is still being written.
  xsde_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_i       (pop),
    .pop_data_o  (back_cmd)
  );

  // Back end: owns the frame store and the collision flag, and produces exactly
  // one result transaction for every command, in order.
  xsde_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (queue_valid),
    .cmd_i          (back_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/xsde_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xsde_front (
  input  wire logic           start,
  input  wire xsde_pkg::item_t item_i,
  input  wire logic           queue_full_i,
  output logic                push_o,
  output xsde_pkg::cmd_t      cmd_o
);

  logic [xsde_pkg::XW-1:0] x_mod;
  logic [xsde_pkg::YW-1:0] y_mod;
  logic [xsde_pkg::SW-1:0] row_sum;
  logic [xsde_pkg::YW-1:0] row;
  logic [xsde_pkg::AW-1:0] base;
  logic [xsde_pkg::CW-1:0] col_a;
  logic [xsde_pkg::CW-1:0] col_b;
  logic [15:0]             wide;
  xsde_pkg::kind_e         kind;

  assign push_o = start && !queue_full_i;

  always_comb begin
    kind    = xsde_pkg::kind_e'(item_i.kind);
    x_mod   = xsde_pkg::XMOD_TAB[item_i.x_coord];
    y_mod   = xsde_pkg::YMOD_TAB[item_i.y_coord];
    row_sum = xsde_pkg::SW'(y_mod) + xsde_pkg::SW'(item_i.row_offset);
    row     = xsde_pkg::RMOD_TAB[row_sum];
    base    = xsde_pkg::AW'(int'(row) * xsde_pkg::ROW_BYTES);
    col_a   = xsde_pkg::CW'(x_mod >> 3);
    // The second byte wraps to the start of the same row.
    if (col_a == xsde_pkg::CW'(xsde_pkg::ROW_BYTES - 1)) begin
      col_b = '0;
    end else begin
      col_b = col_a + 1'b1;
    end
    wide = {8'h00, xsde_pkg::flip8(item_i.row_bits)} << x_mod[2:0];

    cmd_o.op        = kind;
    cmd_o.first_row = item_i.first_row;
    cmd_o.last_row  = item_i.last_row;
    cmd_o.in_range  = ({24'd0, item_i.read_addr} < 32'(xsde_pkg::STORE_BYTES));
    cmd_o.pat_a     = wide[7:0];
    cmd_o.pat_b     = wide[15:8];
    cmd_o.addr_b    = base + xsde_pkg::AW'(col_b);
    if (kind == xsde_pkg::KIND_READ) begin
      cmd_o.addr_a = xsde_pkg::AW'(item_i.read_addr);
    end else begin
      cmd_o.addr_a = base + xsde_pkg::AW'(col_a);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/xsde_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xsde_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire xsde_pkg::cmd_t push_data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output xsde_pkg::cmd_t      pop_data_o
);

  xsde_pkg::cmd_t                entry_q [xsde_pkg::QUEUE_DEPTH];
  logic [xsde_pkg::QPW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [xsde_pkg::QPW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [xsde_pkg::QPW:0]        count_q, count_d;

  assign full_o     = (count_q == (xsde_pkg::QPW+1)'(xsde_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == xsde_pkg::QPW'(xsde_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == xsde_pkg::QPW'(xsde_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/xsde_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xsde_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire xsde_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output xsde_pkg::result_t   result_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDATA = 2'd1;
  localparam logic [1:0] S_RD1   = 2'd2;
  localparam logic [1:0] S_RD2   = 2'd3;

  logic [7:0]                    mem_q [xsde_pkg::STORE_BYTES];
  logic [xsde_pkg::STORE_BYTES-1:0] valid_q;
  logic [7:0]                    rd_q;
  logic                          rd_valid_q;

  logic [1:0]              state_q, state_d;
  xsde_pkg::cmd_t          cmd_q, cmd_d;
  logic                    acc_q, acc_d;
  logic                    hit_q, hit_d;
  logic                    res_valid_q, res_valid_d;
  xsde_pkg::result_t       res_q, res_d;

  logic                    rd_en;
  logic [xsde_pkg::AW-1:0] rd_addr;
  logic                    wr_en;
  logic [xsde_pkg::AW-1:0] wr_addr;
  logic [7:0]              wr_data;
  logic                    clear_all;
  logic [7:0]              old_byte;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A byte never written since the last clear reads as blank.
  assign old_byte = rd_valid_q ? rd_q : 8'h00;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    acc_d       = acc_q;
    hit_d       = hit_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cmd_i.addr_a;
    wr_en       = 1'b0;
    wr_addr     = cmd_q.addr_a;
    wr_data     = old_byte ^ cmd_q.pat_a;
    clear_all   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          case (cmd_i.op)
            xsde_pkg::KIND_DRAW: begin
              rd_en   = 1'b1;
              if (cmd_i.first_row) begin
                acc_d = 1'b0;
              end
              state_d = S_RD1;
            end
            xsde_pkg::KIND_READ: begin
              rd_en   = cmd_i.in_range;
              state_d = S_RDATA;
            end
            xsde_pkg::KIND_CLEAR: begin
              clear_all         = 1'b1;
              res_valid_d       = 1'b1;
              res_d.collision   = acc_q;
            end
            default: begin
              res_valid_d       = 1'b1;
              res_d.collision   = acc_q;
            end
          endcase
        end
      end
      S_RDATA: begin
        res_valid_d     = 1'b1;
        res_d.collision = acc_q;
        res_d.read_data = cmd_q.in_range ? old_byte : 8'h00;
        state_d         = S_IDLE;
      end
      S_RD1: begin
        wr_en   = 1'b1;
        hit_d   = |(old_byte & cmd_q.pat_a);
        rd_en   = 1'b1;
        rd_addr = cmd_q.addr_b;
        state_d = S_RD2;
      end
      S_RD2: begin
        wr_en             = 1'b1;
        wr_addr           = cmd_q.addr_b;
        wr_data           = old_byte ^ cmd_q.pat_b;
        acc_d             = acc_q | hit_q | (|(old_byte & cmd_q.pat_b));
        res_valid_d       = 1'b1;
        res_d.collision   = acc_d;
        res_d.sprite_done = cmd_q.last_row;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= 1'b0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      res_valid_q <= res_valid_d;
      if (clear_all) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    hit_q <= hit_d;
    res_q <= res_d;
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
  end

endmodule

`default_nettype wire
